// ----- src/pfd_pkg.sv -----
package pfd_pkg;

    // operand widths of the shared serial units
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 33;
    localparam int MUL_PW = MUL_AW + MUL_BW + 1;
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;

    // drive accumulator, wide enough for the integral product after scaling
    localparam int ACC_W = MUL_PW - 16;

    localparam logic [31:0] RC_Q16 = 32'd522;

    localparam int CFG_IW = 4;

    typedef enum logic [CFG_IW-1:0] {
        REG_PROP_GAIN    = 4'd0,
        REG_DERIV_GAIN   = 4'd1,
        REG_INTEG_GAIN   = 4'd2,
        REG_INTEG_LIMIT  = 4'd3,
        REG_OUT_LOW      = 4'd4,
        REG_OUT_HIGH     = 4'd5,
        REG_BOUND_ENABLE = 4'd6,
        REG_ENABLE       = 4'd7
    } reg_index_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (x > hi) return 32'sh7FFF_FFFF;
        if (x < lo) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF_FFFF);
        lo = -hi - ACC_W'(1);
        if (x > hi) return 48'sh7FFF_FFFF_FFFF;
        if (x < lo) return 48'sh8000_0000_0000;
        return x[47:0];
    endfunction

endpackage

// ----- src/pfd_serial_mul.sv -----
module pfd_serial_mul #(
    parameter int AW = pfd_pkg::MUL_AW,
    parameter int BW = pfd_pkg::MUL_BW
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic                     done,
    output logic signed [AW+BW:0]    p
);
    import pfd_pkg::*;

    localparam int CW = $clog2(BW);

    logic signed [AW:0]   hi_reg;
    logic [BW-1:0]        lo_reg;
    logic signed [AW-1:0] a_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [AW:0]   a_ext;
    logic                 last;
    logic signed [AW:0]   sum;

    assign a_ext = {a_reg[AW-1], a_reg};
    assign last  = (cnt_reg == CW'(BW - 1));

    // multiplier bit serial, LSB first; sign bit of b carries negative weight
    always_comb begin
        if (lo_reg[0]) begin
            sum = last ? (hi_reg - a_ext) : (hi_reg + a_ext);
        end else begin
            sum = hi_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                hi_reg   <= '0;
                lo_reg   <= b;
                a_reg    <= a;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                hi_reg  <= {sum[AW], sum[AW:1]};
                lo_reg  <= {sum[0], lo_reg[BW-1:1]};
                cnt_reg <= cnt_reg + CW'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign p    = {hi_reg, lo_reg};

endmodule

// ----- src/pfd_serial_div.sv -----
module pfd_serial_div #(
    parameter int NW = pfd_pkg::DIV_NW,
    parameter int DW = pfd_pkg::DIV_DW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic          done,
    output logic [NW-1:0] q
);
    import pfd_pkg::*;

    localparam int CW = $clog2(NW);

    logic [DW-1:0] rem_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   r2;
    logic          ge;
    logic [DW:0]   diff;
    logic          last;

    // restoring division, one quotient bit per cycle
    assign r2   = {rem_reg, num_reg[NW-1]};
    assign ge   = (r2 >= {1'b0, den_reg});
    assign diff = r2 - {1'b0, den_reg};
    assign last = (cnt_reg == CW'(NW - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                num_reg  <= n;
                den_reg  <= d;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? diff[DW-1:0] : r2[DW-1:0];
                num_reg <= {num_reg[NW-2:0], ge};
                cnt_reg <= cnt_reg + CW'(1);
                if (last) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign q    = num_reg;

endmodule

// ----- src/pid_filtered_derivative_top.sv -----
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-----------------------------------
// s_       | in        | s_valid / s_ready     | s_measured, s_setpoint, s_elapsed
// m_       | out       | m_valid / m_ready     | m_drive
// cfg_     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One beat at a time. A normal step runs two serial divides and five serial
// multiplies between the prep and finish states; the first step after reset
// or a register write runs only three multiplies, and a disabled step goes
// straight from prep to finish.
// The serial units set the length of a step.
// Synchronous active-low reset; control and register-file registers come up at their reset values.
// The output register holds a result while m_ready is low; the next input
// beat is taken meanwhile, and the step stalls at its end until the output frees.
// Register writes are taken only while no step is running (cfg_ready low otherwise).
module pid_filtered_derivative_top (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [31:0]          s_measured,
    input  logic signed [31:0]          s_setpoint,
    input  logic [15:0]                 s_elapsed,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [31:0]          m_drive,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pfd_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [31:0]                 cfg_data
);
    import pfd_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_PREP = 10'b00_0000_0010,
        ST_DIVA = 10'b00_0000_0100,   // alpha = dt<<32 / (dt<<16 + rc)
        ST_DIVR = 10'b00_0000_1000,   // raw derivative = delta err / dt
        ST_MULD = 10'b00_0001_0000,   // alpha * (raw - prev)
        ST_MULI = 10'b00_0010_0000,   // err * dt
        ST_MULP = 10'b00_0100_0000,   // kp * err
        ST_MULK = 10'b00_1000_0000,   // kd * deriv
        ST_MULG = 10'b01_0000_0000,   // ki * integral
        ST_FIN  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // registers
    logic signed [31:0] prop_gain_reg, deriv_gain_reg, integ_gain_reg;
    logic [30:0]        integ_limit_reg;
    logic signed [31:0] out_low_reg, out_high_reg;
    logic               bound_en_reg, en_reg;

    // controller state
    logic signed [47:0] integ_reg;
    logic signed [31:0] prev_err_reg, prev_d_reg;
    logic               first_reg;

    // per-step working values
    logic signed [31:0]      err_reg, deriv_reg;
    logic [15:0]             dt_reg, alpha_reg;
    logic                    neg_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [31:0]      drive_reg;
    logic                    m_valid_reg;

    // serial units
    logic                     mul_start, mul_done;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] mul_p;
    logic                     div_start, div_done;
    logic [DIV_NW-1:0]        div_n, div_q;
    logic [DIV_DW-1:0]        div_d;

    pfd_serial_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
        .aclk, .aresetn, .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .p(mul_p)
    );

    pfd_serial_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
        .aclk, .aresetn, .start(div_start), .n(div_n), .d(div_d),
        .done(div_done), .q(div_q)
    );

    // datapath terms
    logic signed [31:0]      err_in;
    logic [15:0]             dt_in;
    logic signed [32:0]      derr;
    logic [32:0]             derr_mag;
    logic signed [33:0]      raw34;
    logic signed [31:0]      raw;
    logic signed [32:0]      raw_minus_prev;
    logic signed [ACC_W-1:0] p_scaled;
    logic signed [ACC_W-1:0] acc_lo, acc_cl;
    logic signed [31:0]      drive_final;
    logic signed [47:0]      lim48;
    logic                    out_free;
    logic                    cfg_hit;

    assign err_in = sat32(ACC_W'(s_measured) - ACC_W'(s_setpoint));
    assign dt_in  = (s_elapsed == 16'd0) ? 16'd1 : s_elapsed;

    assign derr     = 33'(err_reg) - 33'(prev_err_reg);
    assign derr_mag = derr[32] ? 33'(-derr) : derr;

    // quotient magnitude fits 33 bits; sign restored after the divide
    assign raw34 = neg_reg ? -$signed({1'b0, div_q[32:0]}) : $signed({1'b0, div_q[32:0]});
    assign raw   = sat32(ACC_W'(raw34));
    assign raw_minus_prev = 33'(raw) - 33'(prev_d_reg);

    // floor(p / 2^16)
    assign p_scaled = mul_p[MUL_PW-1:16];

    assign acc_lo = (bound_en_reg && acc_reg < ACC_W'(out_low_reg)) ? ACC_W'(out_low_reg)
                                                                      : acc_reg;
    assign acc_cl = (bound_en_reg && acc_lo > ACC_W'(out_high_reg)) ? ACC_W'(out_high_reg)
                                                                     : acc_lo;
    assign drive_final = en_reg ? sat32(acc_cl) : 32'sd0;

    assign lim48    = $signed({17'd0, integ_limit_reg});
    assign out_free = !m_valid_reg || m_ready;
    assign cfg_hit  = cfg_valid && cfg_ready && (cfg_index <= REG_ENABLE);

    // sequencer: each state launches the next unit on the previous one's done
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        div_n      = '0;
        div_d      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                if (!en_reg) begin
                    state_next = ST_FIN;
                end else if (first_reg) begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_AW'(err_reg);
                    mul_b      = MUL_BW'(prop_gain_reg);
                    state_next = ST_MULP;
                end else begin
                    div_start  = 1'b1;
                    div_n      = {dt_reg, 32'd0};
                    div_d      = {dt_reg, 16'd0} + RC_Q16;
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (div_done) begin
                    div_start  = 1'b1;
                    div_n      = DIV_NW'(derr_mag);
                    div_d      = DIV_DW'(dt_reg);
                    state_next = ST_DIVR;
                end
            end
            ST_DIVR: begin
                if (div_done) begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_AW'(raw_minus_prev);
                    mul_b      = $signed({17'd0, alpha_reg});
                    state_next = ST_MULD;
                end
            end
            ST_MULD: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_AW'(err_reg);
                    mul_b      = $signed({17'd0, dt_reg});
                    state_next = ST_MULI;
                end
            end
            ST_MULI: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_AW'(err_reg);
                    mul_b      = MUL_BW'(prop_gain_reg);
                    state_next = ST_MULP;
                end
            end
            ST_MULP: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_AW'(deriv_reg);
                    mul_b      = MUL_BW'(deriv_gain_reg);
                    state_next = ST_MULK;
                end
            end
            ST_MULK: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = integ_reg;
                    mul_b      = MUL_BW'(integ_gain_reg);
                    state_next = ST_MULG;
                end
            end
            ST_MULG: begin
                if (mul_done) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            prop_gain_reg   <= '0;
            deriv_gain_reg  <= '0;
            integ_gain_reg  <= '0;
            integ_limit_reg <= '0;
            out_low_reg     <= 32'sh8000_0000;
            out_high_reg    <= 32'sh7FFF_FFFF;
            bound_en_reg    <= 1'b0;
            en_reg          <= 1'b0;
            integ_reg       <= '0;
            prev_err_reg    <= '0;
            prev_d_reg      <= '0;
            first_reg       <= 1'b1;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == ST_MULI && mul_done) begin
                integ_reg <= sat48(ACC_W'(integ_reg) + ACC_W'(mul_p));
            end

            if (state_reg == ST_FIN && out_free && en_reg) begin
                prev_err_reg <= err_reg;
                prev_d_reg   <= deriv_reg;
                first_reg    <= 1'b0;
                // anti-windup applies from the next step on
                if (bound_en_reg) begin
                    if (integ_reg < -lim48) begin
                        integ_reg <= -lim48;
                    end else if (integ_reg > lim48) begin
                        integ_reg <= lim48;
                    end
                end
            end

            // any listed register write also restarts the controller
            if (cfg_hit) begin
                case (reg_index_t'(cfg_index))
                    REG_PROP_GAIN:    prop_gain_reg   <= cfg_data;
                    REG_DERIV_GAIN:   deriv_gain_reg  <= cfg_data;
                    REG_INTEG_GAIN:   integ_gain_reg  <= cfg_data;
                    REG_INTEG_LIMIT:  integ_limit_reg <= cfg_data[30:0];
                    REG_OUT_LOW:      out_low_reg     <= cfg_data;
                    REG_OUT_HIGH:     out_high_reg    <= cfg_data;
                    REG_BOUND_ENABLE: bound_en_reg    <= cfg_data[0];
                    REG_ENABLE:       en_reg          <= cfg_data[0];
                    default: ;
                endcase
                integ_reg    <= '0;
                prev_err_reg <= '0;
                prev_d_reg   <= '0;
                first_reg    <= 1'b1;
            end
        end
    end

    // working values, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            err_reg <= err_in;
            dt_reg  <= dt_in;
        end
        if (state_reg == ST_PREP) begin
            deriv_reg <= '0;
        end
        if (state_reg == ST_DIVA && div_done) begin
            alpha_reg <= div_q[15:0];
            neg_reg   <= derr[32];
        end
        if (state_reg == ST_MULD && mul_done) begin
            deriv_reg <= sat32(ACC_W'(prev_d_reg) + p_scaled);
        end
        if (state_reg == ST_MULP && mul_done) begin
            acc_reg <= p_scaled;
        end
        if ((state_reg == ST_MULK || state_reg == ST_MULG) && mul_done) begin
            acc_reg <= acc_reg + p_scaled;
        end
        if (state_reg == ST_FIN && out_free) begin
            drive_reg <= drive_final;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_drive   = drive_reg;
    assign cfg_ready = (state_reg == ST_IDLE);

endmodule

// ----- src/pfd_checker.sv -----
module pfd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic signed [31:0]          s_measured,
    input logic signed [31:0]          s_setpoint,
    input logic [15:0]                 s_elapsed,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [31:0]          m_drive,
    input logic                        cfg_valid,
    input logic                        cfg_ready,
    input logic [pfd_pkg::CFG_IW-1:0]  cfg_index,
    input logic [31:0]                 cfg_data
);
    import pfd_pkg::*;

    // no result right out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // one beat in flight: busy right after an accept
    a_single_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a step is in flight");

    // a result never appears in the cycle after an accept
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared too early");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_drive)))
        else $error("stalled result changed");

endmodule

bind pid_filtered_derivative_top pfd_checker u_pfd_checker (.*);

// ----- test/pid_filtered_derivative_checker.sv -----
`timescale 1ns / 1ps

module pid_filtered_derivative_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic signed [31:0]         s_measured,
    input  logic signed [31:0]         s_setpoint,
    input  logic [15:0]                s_elapsed,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [31:0]         m_drive,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [pfd_pkg::CFG_IW-1:0] cfg_index,
    input  logic [31:0]                cfg_data,
    output int                         fail_count,
    output int                         drive_pending
);
    import pfd_pkg::*;

    localparam longint S32_HI = 64'sh7FFF_FFFF;
    localparam longint S32_LO = -64'sh8000_0000;
    localparam longint S48_HI = 64'sh7FFF_FFFF_FFFF;
    localparam longint S48_LO = -64'sh8000_0000_0000;

    // gains and clamps
    longint kp, kd, ki, ilim, lo_clamp, hi_clamp;
    bit     bound_on, ctl_on;
    // controller state
    longint integ, last_err, last_deriv;
    bit     fresh;

    logic signed [31:0] drive_q[$];

    function automatic longint clip(longint x, longint lo, longint hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    // arithmetic shift floors; relies on >>> on signed longint
    function automatic longint fshr16(longint x);
        return x >>> 16;
    endfunction

    // 128-bit product floor-shifted, since gain * integral-low fits but
    // gain * 48-bit values can exceed 64 bits only in the integral term
    function automatic longint mulshr(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return longint'(p >>> 16);
    endfunction

    function automatic void wipe_state();
        integ = 0;
        last_err = 0;
        last_deriv = 0;
        fresh = 1;
    endfunction

    function automatic logic signed [31:0] predict_drive(longint meas, longint sp,
                                                         longint el);
        longint err, dt, deriv, raw, alpha, ih, il, acc;
        logic signed [127:0] wide;
        if (!ctl_on) return 32'sd0;
        err = clip(meas - sp, S32_LO, S32_HI);
        dt = (el == 0) ? 1 : el;
        deriv = 0;
        if (!fresh) begin
            raw = clip((err - last_err) / dt, S32_LO, S32_HI);
            alpha = longint'((64'(dt) << 32) / ((64'(dt) << 16) + 64'd522));
            deriv = clip(last_deriv + fshr16(alpha * (raw - last_deriv)), S32_LO, S32_HI);
            integ = clip(integ + err * dt, S48_LO, S48_HI);
        end
        ih = fshr16(integ);
        il = integ - ih * 65536;
        wide = 128'(mulshr(kp, err)) + 128'(mulshr(kd, deriv))
             + 128'(ki) * 128'(ih) + 128'(mulshr(ki, il));
        last_err = err;
        last_deriv = deriv;
        if (bound_on) begin
            if (wide < 128'(lo_clamp)) wide = 128'(lo_clamp);
            if (wide > 128'(hi_clamp)) wide = 128'(hi_clamp);
            integ = clip(integ, -ilim, ilim);
        end
        if (wide > 128'(S32_HI)) acc = S32_HI;
        else if (wide < 128'(S32_LO)) acc = S32_LO;
        else acc = longint'(wide);
        fresh = 0;
        return acc[31:0];
    endfunction

    assign drive_pending = drive_q.size();

    always @(posedge aclk) begin
        logic signed [31:0] want;
        if (!aresetn) begin
            kp = 0; kd = 0; ki = 0; ilim = 0;
            lo_clamp = S32_LO; hi_clamp = S32_HI;
            bound_on = 0; ctl_on = 0;
            wipe_state();
            drive_q.delete();
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected drive beat, expected none, actual %0d",
                             $time, m_drive);
                    fail_count <= fail_count + 1;
                end else begin
                    want = drive_q.pop_front();
                    if (want !== m_drive) begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, want, m_drive);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // a write in the accept cycle already applies to that step
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROP_GAIN:    kp = longint'($signed(cfg_data));
                    REG_DERIV_GAIN:   kd = longint'($signed(cfg_data));
                    REG_INTEG_GAIN:   ki = longint'($signed(cfg_data));
                    REG_INTEG_LIMIT:  ilim = longint'(cfg_data[30:0]);
                    REG_OUT_LOW:      lo_clamp = longint'($signed(cfg_data));
                    REG_OUT_HIGH:     hi_clamp = longint'($signed(cfg_data));
                    REG_BOUND_ENABLE: bound_on = cfg_data[0];
                    REG_ENABLE:       ctl_on = cfg_data[0];
                    default:          ;
                endcase
                if (cfg_index <= REG_ENABLE) wipe_state();
            end
            if (s_valid && s_ready)
                drive_q.push_back(predict_drive(longint'(s_measured),
                                                longint'(s_setpoint),
                                                longint'(s_elapsed)));
        end
    end
endmodule

// ----- test/pid_filtered_derivative_top_tb.sv -----
`timescale 1ns / 1ps

module pid_filtered_derivative_top_tb;
    import pfd_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic signed [31:0]  s_measured;
    logic signed [31:0]  s_setpoint;
    logic [15:0]         s_elapsed;
    logic                m_valid;
    logic                m_ready;
    logic signed [31:0]  m_drive;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index;
    logic [31:0]         cfg_data;
    int                  fail_count;
    int                  drive_pending;
    bit                  stall_enable;

    pid_filtered_derivative_top u_top (.*);

    pid_filtered_derivative_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Receiver backpressure: random stalls, short mostly, sometimes long,
    // plus stretches of always-ready.
    initial begin
        int n;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (!stall_enable || $urandom_range(0, 2) != 0) begin
                m_ready <= 1;
            end else begin
                m_ready <= 0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400)
                                                 : $urandom_range(1, 4);
                repeat (n) @(posedge aclk);
                m_ready <= 1;
            end
        end
    end

    // Hard stop: fails the run if the 976 items with receiver stalls have not all finished.
    initial begin
        #(40_000_000);
        $display("pid_filtered_derivative_top regression: fail");
        $finish;
    end

    // idle gap with valid low, sometimes a longer one
    task automatic idle_gap();
        int n;
        n = 1;
        if ($urandom_range(0, 3) == 0)
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 600) : $urandom_range(1, 5);
        repeat (n) @(posedge aclk);
    endtask

    // one input beat: hold valid until accepted
    task automatic send_step(logic [31:0] meas, logic [31:0] sp, logic [15:0] el);
        s_valid    <= 1;
        s_measured <= meas;
        s_setpoint <= sp;
        s_elapsed  <= el;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        s_valid <= 0;
        idle_gap();
    endtask

    // wait for all drive beats, then let the pipeline drain
    task automatic drain();
        @(posedge aclk);
        while (drive_pending != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 255) << 16;
            3: return -($urandom_range(0, 255) << 16);
            4: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rnd_dt();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 20));
        endcase
    endfunction

    function automatic logic [31:0] rnd_gain();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom_range(0, 4) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom_range(0, 8 << 16) - (4 << 16);
        endcase
    endfunction

    // one configuration phase: every register, random values with extremes
    task automatic random_setup(bit bound, bit en);
        logic [31:0] a, b;
        a = rnd_val();
        b = rnd_val();
        write_reg(REG_PROP_GAIN, rnd_gain());
        write_reg(REG_DERIV_GAIN, rnd_gain());
        write_reg(REG_INTEG_GAIN, rnd_gain());
        write_reg(REG_INTEG_LIMIT, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24));
        // mostly ordered clamps, occasionally crossed
        if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b)) begin
            write_reg(REG_OUT_LOW, b);
            write_reg(REG_OUT_HIGH, a);
        end else begin
            write_reg(REG_OUT_LOW, a);
            write_reg(REG_OUT_HIGH, b);
        end
        write_reg(REG_BOUND_ENABLE, {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0, bound});
        write_reg(REG_ENABLE, {31'($urandom), en});
    endtask

    initial begin
        s_valid = 0;
        s_measured = 0;
        s_setpoint = 0;
        s_elapsed = 0;
        cfg_valid = 0;
        cfg_index = REG_PROP_GAIN;
        cfg_data = 0;
        stall_enable = 0;
        aresetn = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // disabled after reset: drive stays zero
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);
        send_step(32'h1234_5678, 32'h0, 16'd5);
        drain();

        // directed: gains of 1.0, 0.5 and 0.25 in Q16.16, no bounding
        write_reg(REG_PROP_GAIN, 32'h0001_0000);
        write_reg(REG_DERIV_GAIN, 32'h0000_8000);
        write_reg(REG_INTEG_GAIN, 32'h0000_4000);
        write_reg(REG_ENABLE, 32'd1);
        send_step(32'h0002_0000, 32'h0001_0000, 16'd1);   // first step
        send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'd0);   // error saturates, dt 0
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_step(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        send_step(32'h0, 32'h0, 16'd10);
        drain();

        // directed: bounding with anti-windup and extreme gains
        write_reg(REG_PROP_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_DERIV_GAIN, 32'h8000_0000);
        write_reg(REG_INTEG_GAIN, 32'h7FFF_FFFF);
        write_reg(REG_INTEG_LIMIT, 32'h7FFF_FFFF);
        write_reg(REG_OUT_LOW, 32'hFFF0_0000);
        write_reg(REG_OUT_HIGH, 32'h0010_0000);
        write_reg(REG_BOUND_ENABLE, 32'd1);
        write_reg(REG_ENABLE, 32'd1);
        repeat (4) send_step(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        send_step(32'h0, 32'h0, 16'd1);
        drain();
        // zero limit, crossed clamps: drive equals out_high
        write_reg(REG_INTEG_LIMIT, 32'd0);
        write_reg(REG_OUT_LOW, 32'h0100_0000);
        write_reg(REG_OUT_HIGH, 32'hFF00_0000);
        write_reg(REG_BOUND_ENABLE, 32'd1);
        repeat (3) send_step(rnd_val(), rnd_val(), rnd_dt());
        drain();
        // write to an index past the list
        write_reg(reg_index_t'(4'd9), 32'hFFFF_FFFF);
        write_reg(reg_index_t'(4'd15), 32'h0);
        send_step(32'h0001_0000, 32'h0, 16'd3);
        drain();

        // random phases
        stall_enable = 1;
        for (int ph = 0; ph < 40; ph++) begin
            random_setup(1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
            repeat (24) begin
                // mostly slowly varying signals so the filter state builds
                if ($urandom_range(0, 3) == 0)
                    send_step(rnd_val(), rnd_val(), rnd_dt());
                else
                    send_step($urandom_range(0, 1 << 22) - (1 << 21),
                              $urandom_range(0, 1 << 22) - (1 << 21),
                              16'($urandom_range(0, 30)));
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("pid_filtered_derivative_top regression: pass");
        end else begin
            $display("pid_filtered_derivative_top regression: fail");
        end
        $finish;
    end
endmodule
